// ===== rtl/bats_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bats_pkg: shared types and constants for the block average symbol generator
// Payload structs, arithmetic constants and the symbol lookup used by the
// accumulator, the symbol stage and the port checker.
// ----------------------------------------------------------------------------
package bats_pkg;

   localparam int MAX_WIDTH_DEF = 1024;

   localparam int CFG_W     = 11;
   localparam int PIXEL_W   = 8;
   localparam int SYMBOL_W  = 6;
   localparam int ROW_SUM_W = 10;
   localparam int SUM_W     = 12;
   localparam int LEVEL_W   = 4;

   localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(640);
   localparam int MIN_WIDTH = 3;

   // The nine-pixel sum is divided by 9 and then by 24; both floors fold
   // into one floor by their product.
   localparam int AVG_DIV    = 9;
   localparam int LEVEL_DIV  = 24;
   localparam int LEVEL_STEP = AVG_DIV * LEVEL_DIV;
   localparam int LEVEL_MAX  = 10;

   // floor(w / 3) == (w * RECIP_3) >> RECIP_SH for every w below 2**15.
   localparam int RECIP_3  = 10923;
   localparam int RECIP_SH = 15;
   localparam int RECIP_W  = 14;

   // Column and row position inside a 3x3 block.
   localparam logic [1:0] PHASE_FIRST = 2'd0;
   localparam logic [1:0] PHASE_MID   = 2'd1;
   localparam logic [1:0] PHASE_LAST  = 2'd2;

   // ASCII codes of the output characters, darkest first.
   localparam logic [SYMBOL_W-1:0] SYM_DOT   = SYMBOL_W'(46);
   localparam logic [SYMBOL_W-1:0] SYM_COLON = SYMBOL_W'(58);
   localparam logic [SYMBOL_W-1:0] SYM_SEMI  = SYMBOL_W'(59);
   localparam logic [SYMBOL_W-1:0] SYM_SEVEN = SYMBOL_W'(55);
   localparam logic [SYMBOL_W-1:0] SYM_TWO   = SYMBOL_W'(50);
   localparam logic [SYMBOL_W-1:0] SYM_FIVE  = SYMBOL_W'(53);
   localparam logic [SYMBOL_W-1:0] SYM_FOUR  = SYMBOL_W'(52);
   localparam logic [SYMBOL_W-1:0] SYM_SIX   = SYMBOL_W'(54);
   localparam logic [SYMBOL_W-1:0] SYM_NINE  = SYMBOL_W'(57);
   localparam logic [SYMBOL_W-1:0] SYM_ZERO  = SYMBOL_W'(48);
   localparam logic [SYMBOL_W-1:0] SYM_EIGHT = SYMBOL_W'(56);

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               frame_start;
   } bats_req_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                last_in_band;
   } bats_rsp_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             last_in_band;
   } bats_blk_type;

   function automatic logic [SYMBOL_W-1:0] symbol_lut(input logic [LEVEL_W-1:0] level);
      logic [SYMBOL_W-1:0] code;
      case (level)
         4'd0:    code = SYM_DOT;
         4'd1:    code = SYM_COLON;
         4'd2:    code = SYM_SEMI;
         4'd3:    code = SYM_SEVEN;
         4'd4:    code = SYM_TWO;
         4'd5:    code = SYM_FIVE;
         4'd6:    code = SYM_FOUR;
         4'd7:    code = SYM_SIX;
         4'd8:    code = SYM_NINE;
         4'd9:    code = SYM_ZERO;
         4'd10:   code = SYM_EIGHT;
         default: code = SYM_EIGHT;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/bats_accum.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bats_accum: position tracking and 3x3 block accumulation
// Holds the width register, the raster position counters, the running row
// sum and the line store of per-block partial sums. A finished block sum is
// registered for the symbol stage.
// ----------------------------------------------------------------------------
module bats_accum
   import bats_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CFG_W-1:0] csr_data,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bats_req_type     req_data,
   output logic                  blk_valid,
   input  wire logic             blk_ready,
   output bats_blk_type          blk_data
);

   localparam int BLOCK_COUNT = MAX_WIDTH / 3;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int EW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
   localparam int PW = EW + RECIP_W;
   localparam int BW = $clog2(BLOCK_COUNT + 1);
   localparam int AW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;

   logic [CFG_W-1:0]     width_ff;
   logic [COL_W-1:0]     pos_ff, pos_in, pos_cur;
   logic [1:0]           cph_ff, cph_in, cph_cur;
   logic [1:0]           rph_ff, rph_in, rph_cur;
   logic [BW-1:0]        bidx_ff, bidx_in, bidx_cur;
   logic [ROW_SUM_W-1:0] row_sum_ff, row_sum_in, row_sum_cur, row_sum_new;
   logic [SUM_W-1:0]     rd_data_ff, band_new;
   logic [SUM_W-1:0]     band_mem [BLOCK_COUNT];
   logic                 blk_valid_ff, blk_valid_in;
   bats_blk_type         blk_data_ff;

   logic [EW-1:0]    cfg_ext, w_eff, blocks, limit;
   logic [PW-1:0]    prod;
   logic [AW-1:0]    addr;
   logic             accept, in_range, row_end, is_last;
   logic             mem_wr, mem_rd, produce;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         width_ff <= csr_data;
      end
   end

   // Clamp the width, then count complete blocks per row.
   always_comb begin
      cfg_ext = EW'(width_ff);
      if (cfg_ext < EW'(MIN_WIDTH)) begin
         w_eff = EW'(MIN_WIDTH);
      end else if (cfg_ext > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = cfg_ext;
      end
      prod   = PW'(w_eff) * PW'(RECIP_3);
      blocks = EW'(prod >> RECIP_SH);
      limit  = (blocks << 1) + blocks;
   end

   assign accept    = req_valid && req_ready;
   assign req_ready = !blk_valid_ff || blk_ready;

   // A frame start clears the position before this pixel is used.
   always_comb begin
      pos_cur     = req_data.frame_start ? '0 : pos_ff;
      cph_cur     = req_data.frame_start ? PHASE_FIRST : cph_ff;
      rph_cur     = req_data.frame_start ? PHASE_FIRST : rph_ff;
      bidx_cur    = req_data.frame_start ? '0 : bidx_ff;
      row_sum_cur = req_data.frame_start ? '0 : row_sum_ff;

      in_range = EW'(pos_cur) < limit;
      row_end  = (EW'(pos_cur) + EW'(1)) >= w_eff;
      is_last  = (EW'(bidx_cur) + EW'(1)) == blocks;

      if (cph_cur == PHASE_FIRST) begin
         row_sum_new = ROW_SUM_W'(req_data.pixel);
      end else begin
         row_sum_new = row_sum_cur + ROW_SUM_W'(req_data.pixel);
      end

      if (rph_cur == PHASE_FIRST) begin
         band_new = SUM_W'(row_sum_new);
      end else begin
         band_new = rd_data_ff + SUM_W'(row_sum_new);
      end

      row_sum_in = in_range ? row_sum_new : row_sum_cur;

      if (row_end) begin
         pos_in  = '0;
         cph_in  = PHASE_FIRST;
         bidx_in = '0;
         rph_in  = (rph_cur == PHASE_LAST) ? PHASE_FIRST : rph_cur + 2'd1;
      end else begin
         pos_in  = pos_cur + COL_W'(1);
         cph_in  = (cph_cur == PHASE_LAST) ? PHASE_FIRST : cph_cur + 2'd1;
         bidx_in = (cph_cur == PHASE_LAST) ? bidx_cur + BW'(1) : bidx_cur;
         rph_in  = rph_cur;
      end

      addr    = bidx_cur[AW-1:0];
      // The line store is read on the middle pixel of a block row so that
      // the data is registered by the time the last pixel arrives.
      mem_rd  = accept && in_range && (cph_cur == PHASE_MID);
      mem_wr  = accept && in_range && (cph_cur == PHASE_LAST);
      produce = mem_wr && (rph_cur == PHASE_LAST);

      blk_valid_in = req_ready ? produce : blk_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         cph_ff       <= PHASE_FIRST;
         rph_ff       <= PHASE_FIRST;
         bidx_ff      <= '0;
         row_sum_ff   <= '0;
         blk_valid_ff <= 1'b0;
      end else begin
         blk_valid_ff <= blk_valid_in;
         if (accept) begin
            pos_ff     <= pos_in;
            cph_ff     <= cph_in;
            rph_ff     <= rph_in;
            bidx_ff    <= bidx_in;
            row_sum_ff <= row_sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         band_mem[addr] <= band_new;
      end
      if (mem_rd) begin
         rd_data_ff <= band_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         blk_data_ff.sum          <= band_new;
         blk_data_ff.last_in_band <= is_last;
      end
   end

   assign blk_valid = blk_valid_ff;
   assign blk_data  = blk_data_ff;

endmodule
`default_nettype wire

// ===== rtl/bats_symbol.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bats_symbol: block sum to character
// Quantizes the nine-pixel sum into one of eleven levels, looks up the
// character and holds it in the result register.
// ----------------------------------------------------------------------------
module bats_symbol
   import bats_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         blk_valid,
   output logic              blk_ready,
   input  wire bats_blk_type blk_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output bats_rsp_type      rsp_data
);

   logic         rsp_valid_ff, rsp_valid_in;
   bats_rsp_type rsp_data_ff, rsp_data_in;
   logic [LEVEL_W-1:0] level;

   assign blk_ready = !rsp_valid_ff || rsp_ready;

   // Level is the number of step thresholds the sum reaches, which also
   // saturates it at the brightest character.
   always_comb begin
      level = '0;
      for (int k = 1; k <= LEVEL_MAX; k++) begin
         if (blk_data.sum >= SUM_W'(LEVEL_STEP * k)) begin
            level = level + LEVEL_W'(1);
         end
      end
      rsp_data_in.symbol       = symbol_lut(level);
      rsp_data_in.last_in_band = blk_data.last_in_band;
      rsp_valid_in             = blk_ready ? blk_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (blk_valid && blk_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== rtl/block_average_to_symbol_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// block_average_to_symbol_top: 3x3 block average to character generator
// Grayscale raster pixels in, one character per complete 3x3 block out.
//
// req_*  : one pixel per transaction in raster order; frame_start restarts
//          the position at row 0, column 0 with that pixel.
// rsp_*  : one character per complete block, with last_in_band set on the
//          last complete block of each band of three rows.
// csr_*  : image width register, always ready; write it only while no
//          pixel is in flight. Reset value is 640.
// One pixel is taken every cycle while req_ready is high. The character for a
// block is registered first in the accumulator, whose line store is read on
// the block's middle column so the read port keeps up, and then in the
// symbol stage.
// Pixels of incomplete trailing columns or rows give no character.
// Reset clears the position counters and empties both stages; the line
// store needs no clearing because each band starts by overwriting it.
// When rsp_ready is low the result waits in its register, the stage in
// front of it still takes one more block, and req_ready then falls.
// ----------------------------------------------------------------------------
module block_average_to_symbol_top
   import bats_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CFG_W-1:0] csr_data,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bats_req_type     req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output bats_rsp_type          rsp_data
);

   logic         blk_valid;
   logic         blk_ready;
   bats_blk_type blk_data;

   bats_accum #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .blk_valid (blk_valid),
      .blk_ready (blk_ready),
      .blk_data  (blk_data)
   );

   bats_symbol u_symbol (
      .clock     (clock),
      .reset     (reset),
      .blk_valid (blk_valid),
      .blk_ready (blk_ready),
      .blk_data  (blk_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== rtl/bats_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bats_checker: port-level checks for the block average symbol generator
// Watches the top level's handshakes and result codes.
// ----------------------------------------------------------------------------
module bats_checker
   import bats_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_ready,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire bats_rsp_type rsp_data
);

   // A stalled result holds its transaction.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // Every character is one of the eleven table codes.
   a_rsp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.symbol == SYM_DOT || rsp_data.symbol == SYM_COLON ||
                     rsp_data.symbol == SYM_SEMI || rsp_data.symbol == SYM_SEVEN ||
                     rsp_data.symbol == SYM_TWO || rsp_data.symbol == SYM_FIVE ||
                     rsp_data.symbol == SYM_FOUR || rsp_data.symbol == SYM_SIX ||
                     rsp_data.symbol == SYM_NINE || rsp_data.symbol == SYM_ZERO ||
                     rsp_data.symbol == SYM_EIGHT))
      else $error("result symbol outside the character table");

   // A new result comes from a pixel taken earlier, through the accumulator and symbol registers.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result appeared without a matching pixel transaction");

   // With the result register empty the block is always ready for a pixel.
   a_req_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while the output side was empty");

endmodule

bind block_average_to_symbol_top bats_checker u_bats_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
